// ----- rtl/sha_pkg.sv -----
// Package for the SHA-256 byte stream hash unit.
// Holds the round constants, initial hash values, the item type, the queue depth and a rotate function.
// Depends on nothing.
package sha_pkg;

	localparam int QueueDepth = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} item_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

endpackage

// ----- rtl/sha_item_queue.sv -----
// Short queue of classified items between the front and the back part.
// Depends on sha_pkg.
module sha_item_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sha_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output sha_pkg::item_t head
);

	localparam int Aw = $clog2(sha_pkg::QueueDepth);

	sha_pkg::item_t mem_q [sha_pkg::QueueDepth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0]   cnt_q;

	assign full      = (cnt_q == (Aw+1)'(sha_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
		end
	end

endmodule

// ----- rtl/sha_core.sv -----
// Back part: block packing, padding, 64-round compression and digest output.
// Depends on sha_pkg.
module sha_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  sha_pkg::item_t item,
	output logic           item_pop,
	output logic [31:0]    digest_word,
	output logic           digest_last,
	output logic           out_valid,
	input  logic           out_stall
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLoad = 3'd2;
	localparam logic [2:0] StRnd  = 3'd3;
	localparam logic [2:0] StAdd  = 3'd4;
	localparam logic [2:0] StOut  = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        fin_q;
	logic        pend_end_q;
	logic        len_done_q;
	logic        pad_more_q;

	logic [31:0] wr, t1, t2, s0, s1;
	logic [7:0]  pad_byte;

	assign item_pop    = (state_q == StIdle) && item_valid;
	assign out_valid   = (state_q == StOut);
	assign digest_word = h_q[oidx_q];
	assign digest_last = (oidx_q == 3'd7);

	always_comb begin
		s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
		wr = (rnd_q < 6'd16) ? w_q[0] : (s1 + w_q[9] + s0 + w_q[0]);
		t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11)
			^ sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::RoundK[rnd_q] + wr;
		t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13)
			^ sha_pkg::ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		pad_byte = (pos_q >= 6'd56 && len_done_q) ? len_q[{~pos_q[2:0], 3'b000} +: 8]
			: (pend_end_q ? 8'h80 : 8'h00);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				if (item_valid && item.present) begin
					w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= item.data;
				end
			end
			StPad: begin
				w_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= pad_byte;
			end
			StLoad: begin
				for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
			end
			StRnd: begin
				for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
				w_q[15] <= wr;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			for (int j = 0; j < 8; j++) h_q[j] <= sha_pkg::InitH[j];
			len_q      <= '0;
			pos_q      <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			fin_q      <= 1'b0;
			pend_end_q <= 1'b0;
			len_done_q <= 1'b0;
			pad_more_q <= 1'b0;
		end else begin
			case (state_q)
				StIdle: begin
					if (item_valid) begin
						if (item.present) begin
							len_q <= len_q + 64'd8;
							pos_q <= pos_q + 6'd1;
						end
						if (item.present && pos_q == 6'd63) begin
							fin_q      <= 1'b0;
							pend_end_q <= item.last;
							state_q    <= StLoad;
						end else if (item.last) begin
							pend_end_q <= 1'b1;
							len_done_q <= 1'b0;
							state_q    <= StPad;
						end
					end
				end
				StPad: begin
					pend_end_q <= 1'b0;
					pos_q      <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						fin_q      <= len_done_q;
						pad_more_q <= !len_done_q;
						state_q    <= StLoad;
					end else if (pos_q == 6'd55 && !len_done_q) begin
						len_done_q <= 1'b1;
					end
				end
				StLoad: begin
					rnd_q   <= '0;
					state_q <= StRnd;
				end
				StRnd: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
					pad_more_q <= 1'b0;
					if (fin_q) begin
						oidx_q  <= '0;
						state_q <= StOut;
					end else if (pend_end_q || pad_more_q) begin
						len_done_q <= 1'b0;
						state_q    <= StPad;
					end else begin
						state_q <= StIdle;
					end
				end
				StOut: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int j = 0; j < 8; j++) h_q[j] <= sha_pkg::InitH[j];
							len_q   <= '0;
							pos_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= StIdle;
						end
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

// ----- rtl/sha256_byte_stream_hash_unit.sv -----
// Top level of the SHA-256 byte stream hash unit.
// Depends on sha_pkg, sha_item_queue and sha_core.
//
// Input beats carry message_byte, byte_present and message_end on a
// valid/stall channel. The front part takes a beat whenever the item queue
// has room, dropping beats that carry neither a byte nor an end, and queues
// the rest. While idle, the back part packs one byte per cycle into the
// block buffer; it takes no bytes while it pads, compresses or sends the
// digest. The 64th byte of a block starts a compression: a load step, 64
// rounds at one per cycle in the single round unit, and an add step.
// An end beat pads the block one byte per cycle and runs one or two
// compressions, then the eight digest words leave on the output channel,
// H0 first, digest_last on the eighth. The back part waits while the
// receiver stalls; the queue keeps taking beats until it is full. Reset
// empties the queue, loads the initial hash values and clears the length.
module sha256_byte_stream_hash_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  message_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic        digest_last
);

	sha_pkg::item_t in_item, head;
	logic full, not_empty, pop, push;

	assign in_item = '{data: message_byte, present: byte_present, last: message_end};
	assign stall   = full;
	assign push    = valid && !full && (byte_present || message_end);

	sha_item_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(in_item), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .item_valid(not_empty), .item(head),
		.item_pop(pop), .digest_word(digest_word), .digest_last(digest_last),
		.out_valid(digest_valid), .out_stall(digest_stall)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |=> digest_valid && $stable(digest_word))
		else $error("digest changed under stall");
	a_no_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> !pop) else $error("item taken during digest output");

endmodule
